[src/fpm_pkg.sv]
// fpm_pkg: shared constants and types for the binary32 multiplier
// no dependencies
package fpm_pkg;

  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0] INF_BITS    = 32'h7f80_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam int          EXP_BIAS    = 127;
  localparam int          FRAC_BITS   = 23;
  localparam logic [4:0]  MAX_DENORM  = 5'd25;

  // classification and unpacked operands passed from front end to back end
  typedef struct packed {
    logic        special;   // result fully decided by special-case logic
    logic [31:0] spec_val;
    logic [31:0] sign;
    logic [23:0] ma;
    logic [23:0] mb;
    logic signed [9:0] xsum;  // xa + xb - bias
  } fpm_front_t;

endpackage

[src/fpm_unpack.sv]
// fpm_unpack: special-case detection and operand normalization
// depends on fpm_pkg
module fpm_unpack (
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output fpm_pkg::fpm_front_t front
);

  logic [30:0] mag_a, mag_b;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [4:0]  ka, kb;
  logic [31:0] sgn;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  always_comb begin
    mag_a = a[30:0];
    mag_b = b[30:0];
    ea = a[30:23];
    eb = b[30:23];
    sgn = (a ^ b) & fpm_pkg::SIGN_BIT;
    ka = lzc24({1'b0, a[22:0]});
    kb = lzc24({1'b0, b[22:0]});
    ma = (ea != 8'd0) ? {1'b1, a[22:0]} : ({1'b0, a[22:0]} << ka);
    mb = (eb != 8'd0) ? {1'b1, b[22:0]} : ({1'b0, b[22:0]} << kb);
    front.sign = sgn;
    front.ma = ma;
    front.mb = mb;
    front.xsum = ((ea != 8'd0) ? $signed({2'b00, ea}) : (10'sd1 - $signed({5'd0, ka})))
               + ((eb != 8'd0) ? $signed({2'b00, eb}) : (10'sd1 - $signed({5'd0, kb})))
               - 10'sd127;
    front.special = 1'b1;
    priority if ({1'b0, mag_a} > fpm_pkg::INF_BITS)
      front.spec_val = a | fpm_pkg::QUIET_BIT;
    else if ({1'b0, mag_b} > fpm_pkg::INF_BITS)
      front.spec_val = b | fpm_pkg::QUIET_BIT;
    else if (mag_a == 31'd0)
      front.spec_val = (eb == 8'hff) ? fpm_pkg::DEFAULT_NAN : sgn;
    else if (mag_b == 31'd0)
      front.spec_val = (ea == 8'hff) ? fpm_pkg::DEFAULT_NAN : sgn;
    else if ({1'b0, mag_a} == fpm_pkg::INF_BITS || {1'b0, mag_b} == fpm_pkg::INF_BITS)
      front.spec_val = sgn | fpm_pkg::INF_BITS;
    else begin
      front.spec_val = 32'd0;
      front.special = 1'b0;
    end
  end

endmodule

[src/fpm_round.sv]
// fpm_round: normalization, denormalization and round to nearest even
// depends on fpm_pkg
module fpm_round (
  input  logic [47:0]        prod,
  input  logic signed [9:0]  xsum,
  input  logic [31:0]        sign,
  output logic [31:0]        result
);

  logic [31:0] hi, lo, lo2, hi2, r;
  logic signed [9:0] x;
  logic [4:0]  sh;
  logic [63:0] p;
  logic [63:0] ext;

  function automatic logic rinc(input logic [31:0] h, input logic [31:0] l);
    return (l == 32'h8000_0000) ? h[0] : l[31];
  endfunction

  always_comb begin
    p = {8'd0, prod, 8'd0};
    hi = p[63:32];
    lo = p[31:0];
    x = xsum;
    if (hi < 32'h0080_0000) begin
      hi = {hi[30:0], lo[31]};
      lo = {lo[30:0], 1'b0};
      x = x - 10'sd1;
    end
    sh = 5'd0;
    ext = 64'd0;
    hi2 = hi;
    lo2 = lo;
    r = 32'd0;
    if (x >= 10'sd0 && x <= 10'sd253) begin
      r = {x[8:0], 23'd0} + sign + hi;
      result = r + {31'd0, rinc(hi, lo)};
    end else if (x > 10'sd253) begin
      result = sign | fpm_pkg::INF_BITS;
    end else begin
      sh = ((-x) > 10'sd25) ? fpm_pkg::MAX_DENORM : 5'((-x));
      ext = {hi, 32'd0} >> sh;
      lo2 = ext[31:0] | {31'd0, (lo != 32'd0)};
      hi2 = hi >> sh;
      r = hi2 + sign;
      result = r + {31'd0, rinc(hi2, lo2)};
    end
  end

endmodule

[src/fp32_multiply.sv]
// fp32_multiply: binary32 multiplier, round to nearest even
// registers: the input register, then the result register, lie between input transaction and result
// throughput: one transaction per cycle unless the output stalls; the 24x24 significand multiply sets the path
// reset: rst_n synchronous active low clears the valid bits; payload is not reset
// depends on fpm_pkg, fpm_unpack, fpm_round
module fp32_multiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] product
);

  // pipeline advances whenever the result slot is free or being drained
  logic                s1_valid_r, out_valid_r;
  logic [31:0]         a_r, b_r;
  logic [31:0]         res_r, res_nxt;
  logic                adv;
  fpm_pkg::fpm_front_t front;
  logic [47:0]         prod;
  logic [31:0]         rounded;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_tvalid;
      out_valid_r <= s1_valid_r;
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      a_r <= in_tdata[31:0];
      b_r <= in_tdata[63:32];
    end
  end

  fpm_unpack u_unpack (.a(a_r), .b(b_r), .front(front));

  // single 24x24 significand product
  assign prod = front.ma * front.mb;

  fpm_round u_round (.prod(prod), .xsum(front.xsum), .sign(front.sign), .result(rounded));

  assign res_nxt = front.special ? front.spec_val : rounded;

  // result register
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // a stalled result must hold its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // accepted transaction reaches output stage through the operand and result registers when not stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 in_tready |=> out_tvalid)
    else $error("result lost in pipeline");

  // ready only drops while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("stalled without pending result");

endmodule
